// File: rtl/slml_pkg.sv
// ----------------------------------------------------------------------------
// slml_pkg
// Shared codes and control types for the single-linkage merge-level core.
// ----------------------------------------------------------------------------
`default_nettype none

package slml_pkg;

	// command codes
	localparam logic [1:0] CMD_MERGE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_SAME  = 2'd2;
	localparam logic [1:0] ST_MANY  = 2'd3;

	// node_count after reset
	localparam logic [4:0] NODE_COUNT_RESET = 5'd16;

	// control from the sequencer to the label unit
	typedef struct packed {
		logic reset_all;   // every node back to its own label
		logic load_masks;  // capture membership of components A and B
		logic relabel;     // move component B onto label A
	} lbl_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/slml_labels.sv
// ----------------------------------------------------------------------------
// slml_labels
// Component labels, one per node, with a single read port and registered
// membership masks for the two components being merged.
// ----------------------------------------------------------------------------
`default_nettype none

module slml_labels
	import slml_pkg::*;
#(
	parameter int MAX_NODES = 16
) (
	input  wire  logic                               clk,
	input  wire  logic                               arst_n,
	input  wire  lbl_ctrl_t                          ctrl,
	input  wire  logic [$clog2(MAX_NODES)-1:0]       rd_idx,
	output logic       [$clog2(MAX_NODES)-1:0]       rd_label,
	input  wire  logic [$clog2(MAX_NODES)-1:0]       la,
	input  wire  logic [$clog2(MAX_NODES)-1:0]       lb,
	input  wire  logic [$clog2(MAX_NODES+1)-1:0]     n,
	output logic       [MAX_NODES-1:0]               in_a,
	output logic       [MAX_NODES-1:0]               in_b
);

	localparam int NODE_W = $clog2(MAX_NODES);

	logic [NODE_W-1:0]    labels_q [MAX_NODES];
	logic [MAX_NODES-1:0] in_a_q;
	logic [MAX_NODES-1:0] in_b_q;

	// single read port
	assign rd_label = labels_q[rd_idx];
	assign in_a     = in_a_q;
	assign in_b     = in_b_q;

	// labels: reset to identity, relabel B onto A in one pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				labels_q[i] <= NODE_W'(i);
			end
		end else if (ctrl.reset_all) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				labels_q[i] <= NODE_W'(i);
			end
		end else if (ctrl.relabel) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				if (in_b_q[i]) begin
					labels_q[i] <= la;
				end
			end
		end
	end

	// membership masks, limited to the active nodes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_a_q <= '0;
			in_b_q <= '0;
		end else if (ctrl.load_masks) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				in_a_q[i] <= (labels_q[i] == la) && (i < int'(n));
				in_b_q[i] <= (labels_q[i] == lb) && (i < int'(n));
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/single_linkage_merge_levels_core.sv
// ----------------------------------------------------------------------------
// single_linkage_merge_levels_core
// Builds a single-linkage merge-level matrix from spanning-tree edges. A
// merge writes the edge weight to every cross pair of the two components
// and joins them; read returns one level; clear empties the matrix.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   in       | in_valid / in_ready   | cmd, first_node, second_node,
//            |                       | edge_weight
//   out      | out_valid / out_ready | level, status, merges_so_far
//   config   | cfg_we (no wait)      | cfg_wdata -> node_count
//
// A merge scans all n x n pairs through one memory write port and stops
// after the label reads when both ends share a component. A read passes
// S_CHECK, S_RD_WAIT and S_DONE, a rejected item S_CHECK and S_DONE; a clear
// sweeps every entry and at its end resets labels and merge count. in_ready
// rises with result valid. After reset a sweep zeroes the matrix, in_ready low.
// An item whose result finds the previous one still waiting holds until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module single_linkage_merge_levels_core
	import slml_pkg::*;
#(
	parameter int MAX_NODES   = 16,
	parameter int WEIGHT_BITS = 32
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	// configuration
	input  wire  logic        cfg_we,
	input  wire  logic [4:0]  cfg_wdata,
	// input items
	input  wire  logic        in_valid,
	output logic              in_ready,
	input  wire  logic [1:0]  cmd,
	input  wire  logic [3:0]  first_node,
	input  wire  logic [3:0]  second_node,
	input  wire  logic [31:0] edge_weight,
	// result items
	output logic              out_valid,
	input  wire  logic        out_ready,
	output logic [31:0]       level,
	output logic [1:0]        status,
	output logic [3:0]        merges_so_far
);

	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int MEM_DEPTH = MAX_NODES * MAX_NODES;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CHECK,
		S_LA,
		S_LB,
		S_MASK,
		S_SCAN,
		S_RELABEL,
		S_RD_WAIT,
		S_CLEAR,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic [4:0]             node_count_q;
	logic [1:0]             cmd_q;
	logic [3:0]             a_q;
	logic [3:0]             b_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [CNT_W-1:0]       n_q;
	logic [CNT_W-1:0]       merges_q;
	logic [NODE_W-1:0]      la_q;
	logic [NODE_W-1:0]      lb_q;
	logic [NODE_W-1:0]      x_q;
	logic [NODE_W-1:0]      y_q;
	logic [ADDR_W-1:0]      clr_addr_q;
	logic [1:0]             stat_q;
	logic                   rd_level_q;
	logic                   out_valid_q;
	logic [31:0]            level_q;
	logic [1:0]             status_q;
	logic [3:0]             count_q;

	logic [WEIGHT_BITS-1:0] mem [MEM_DEPTH];
	logic [WEIGHT_BITS-1:0] rd_data_q;

	logic [CNT_W-1:0]       n_eff;
	logic [NODE_W-1:0]      lbl_idx;
	logic [NODE_W-1:0]      lbl_rd;
	logic [MAX_NODES-1:0]   in_a;
	logic [MAX_NODES-1:0]   in_b;
	lbl_ctrl_t              lbl_ctrl;
	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_waddr;
	logic [WEIGHT_BITS-1:0] mem_wdata;
	logic [ADDR_W-1:0]      scan_addr;
	logic [ADDR_W-1:0]      rd_addr;
	logic                   pair_hit;
	logic                   out_free;
	logic                   idx_bad;
	logic                   y_last;
	logic                   x_last;

	// node_count clamped to 1..MAX_NODES
	always_comb begin
		if (node_count_q == 5'd0) begin
			n_eff = CNT_W'(1);
		end else if (int'(node_count_q) > MAX_NODES) begin
			n_eff = CNT_W'(MAX_NODES);
		end else begin
			n_eff = CNT_W'(node_count_q);
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// handshake and address helpers
	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign idx_bad   = (int'(a_q) >= int'(n_q)) || (int'(b_q) >= int'(n_q));
	assign y_last    = (int'(y_q) == int'(n_q) - 1);
	assign x_last    = (int'(x_q) == int'(n_q) - 1);
	assign scan_addr = ADDR_W'(x_q) * ADDR_W'(MAX_NODES) + ADDR_W'(y_q);
	assign rd_addr   = ADDR_W'(a_q) * ADDR_W'(MAX_NODES) + ADDR_W'(b_q);
	assign pair_hit  = (in_a[x_q] && in_b[y_q]) || (in_a[y_q] && in_b[x_q]);
	assign lbl_idx   = (state_q == S_LB) ? NODE_W'(b_q) : NODE_W'(a_q);

	// label unit control
	always_comb begin
		lbl_ctrl            = '0;
		lbl_ctrl.load_masks = (state_q == S_MASK);
		lbl_ctrl.relabel    = (state_q == S_RELABEL);
		lbl_ctrl.reset_all  = (state_q == S_CLEAR) &&
			(clr_addr_q == ADDR_W'(MEM_DEPTH - 1));
	end

	// single write port: scan writes or clearing sweep
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = scan_addr;
		mem_wdata = w_q;
		if (state_q == S_SCAN) begin
			mem_we = pair_hit;
		end else if (state_q == S_CLEAR || state_q == S_INIT) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end
	end

	// level memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	slml_labels #(
		.MAX_NODES (MAX_NODES)
	) u_labels (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (lbl_ctrl),
		.rd_idx   (lbl_idx),
		.rd_label (lbl_rd),
		.la       (la_q),
		.lb       (lb_q),
		.n        (n_q),
		.in_a     (in_a),
		.in_b     (in_b)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_addr_q  <= '0;
			merges_q    <= '0;
			out_valid_q <= 1'b0;
			stat_q      <= ST_OK;
			rd_level_q  <= 1'b0;
			cmd_q       <= CMD_MERGE;
			a_q         <= '0;
			b_q         <= '0;
			w_q         <= '0;
			n_q         <= '0;
			la_q        <= '0;
			lb_q        <= '0;
			x_q         <= '0;
			y_q         <= '0;
			level_q     <= '0;
			status_q    <= ST_OK;
			count_q     <= '0;
		end else begin
			// result valid: set when a result is loaded, dropped when taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
						clr_addr_q <= '0;
						state_q    <= S_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + ADDR_W'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q      <= cmd;
						a_q        <= first_node;
						b_q        <= second_node;
						w_q        <= WEIGHT_BITS'(edge_weight);
						n_q        <= n_eff;
						stat_q     <= ST_OK;
						rd_level_q <= 1'b0;
						state_q    <= S_CHECK;
					end
				end
				S_CHECK: begin
					case (cmd_q)
						CMD_MERGE: begin
							if (idx_bad) begin
								stat_q  <= ST_RANGE;
								state_q <= S_DONE;
							end else if (int'(merges_q) >= int'(n_q) - 1) begin
								stat_q  <= ST_MANY;
								state_q <= S_DONE;
							end else begin
								state_q <= S_LA;
							end
						end
						CMD_READ: begin
							if (idx_bad) begin
								stat_q  <= ST_RANGE;
								state_q <= S_DONE;
							end else begin
								rd_level_q <= 1'b1;
								state_q    <= S_RD_WAIT;
							end
						end
						CMD_CLEAR: begin
							clr_addr_q <= '0;
							state_q    <= S_CLEAR;
						end
						default: begin
							stat_q  <= ST_RANGE;
							state_q <= S_DONE;
						end
					endcase
				end
				S_LA: begin
					la_q    <= lbl_rd;
					state_q <= S_LB;
				end
				S_LB: begin
					lb_q <= lbl_rd;
					if (lbl_rd == la_q) begin
						stat_q  <= ST_SAME;
						state_q <= S_DONE;
					end else begin
						state_q <= S_MASK;
					end
				end
				S_MASK: begin
					x_q     <= '0;
					y_q     <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// walk every pair of active nodes, row by row
					if (y_last) begin
						y_q <= '0;
						if (x_last) begin
							state_q <= S_RELABEL;
						end else begin
							x_q <= x_q + NODE_W'(1);
						end
					end else begin
						y_q <= y_q + NODE_W'(1);
					end
				end
				S_RELABEL: begin
					merges_q <= merges_q + CNT_W'(1);
					state_q  <= S_DONE;
				end
				S_RD_WAIT: begin
					state_q <= S_DONE;
				end
				S_CLEAR: begin
					if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
						clr_addr_q <= '0;
						merges_q   <= '0;
						state_q    <= S_DONE;
					end else begin
						clr_addr_q <= clr_addr_q + ADDR_W'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						level_q  <= rd_level_q ? 32'(rd_data_q) : 32'd0;
						status_q <= stat_q;
						count_q  <= 4'(merges_q);
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign level         = level_q;
	assign status        = status_q;
	assign merges_so_far = count_q;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for single_linkage_merge_levels_core. A scoreboard
// class keeps its own merge-level matrix, component labels and merge count,
// predicts one result per accepted item and compares it with what the core
// returns. Stimulus is a directed opening followed by random spanning-tree
// sequences over several node_count settings, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import slml_pkg::*;

	localparam int NODES        = 16;
	localparam int LIMIT_CYCLES = 2_500_000;
	localparam int TAIL_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 140;

	// cmd code the core does not define
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [31:0] level;
		logic [1:0]  status;
		logic [3:0]  count;
	} merge_result_t;

	// Predicts the core's answers and checks them in order.
	class merge_level_tracker;
		logic [31:0]   lvl [NODES][NODES];
		logic [3:0]    comp [NODES];
		int            merge_count;
		logic [4:0]    nodes_cfg;
		merge_result_t expected_q [$];
		int            errors;
		int            checked;
		int            cfg_writes;
		int            cmd_seen [4];
		int            status_seen [4];

		function new();
			nodes_cfg  = NODE_COUNT_RESET;
			errors     = 0;
			checked    = 0;
			cfg_writes = 0;
			for (int i = 0; i < 4; i++) begin
				cmd_seen[i]    = 0;
				status_seen[i] = 0;
			end
			clear_all();
		endfunction

		function void clear_all();
			for (int x = 0; x < NODES; x++) begin
				comp[x] = 4'(x);
				for (int y = 0; y < NODES; y++)
					lvl[x][y] = '0;
			end
			merge_count = 0;
		endfunction

		// node_count clamped to 1..NODES
		function int active_n();
			if (nodes_cfg < 1)
				return 1;
			if (nodes_cfg > NODES)
				return NODES;
			return int'(nodes_cfg);
		endfunction

		function void set_node_count(logic [4:0] v);
			nodes_cfg = v;
			cfg_writes++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// work out the answer to one accepted item
		function void note_item(logic [1:0] c, logic [3:0] a, logic [3:0] b, logic [31:0] w);
			merge_result_t r;
			int            n;
			logic [3:0]    la;
			logic [3:0]    lb;
			n        = active_n();
			r.level  = '0;
			r.status = ST_OK;
			cmd_seen[c]++;
			case (c)
				CMD_MERGE: begin
					if (a >= n || b >= n) begin
						r.status = ST_RANGE;
					end else if (merge_count >= n - 1) begin
						r.status = ST_MANY;
					end else if (comp[a] == comp[b]) begin
						r.status = ST_SAME;
					end else begin
						la = comp[a];
						lb = comp[b];
						// every cross pair gets the edge weight, both halves
						for (int x = 0; x < n; x++) begin
							if (comp[x] == la) begin
								for (int y = 0; y < n; y++) begin
									if (comp[y] == lb) begin
										lvl[x][y] = w;
										lvl[y][x] = w;
									end
								end
							end
						end
						for (int x = 0; x < n; x++)
							if (comp[x] == lb)
								comp[x] = la;
						merge_count++;
					end
				end
				CMD_READ: begin
					if (a >= n || b >= n)
						r.status = ST_RANGE;
					else
						r.level = lvl[a][b];
				end
				CMD_CLEAR: begin
					clear_all();
				end
				default: begin
					r.status = ST_RANGE;
				end
			endcase
			r.count = merge_count[3:0];
			status_seen[r.status]++;
			expected_q.push_back(r);
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 40)
				$display("MISMATCH: %s", msg);
		endtask

		task check_result(logic [31:0] lv, logic [1:0] st, logic [3:0] cnt);
			merge_result_t e;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result with no item pending: level %h status %0d count %0d",
					lv, st, cnt));
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (lv !== e.level)
				report_mismatch($sformatf("result %0d level %h, expected %h", checked, lv, e.level));
			if (st !== e.status)
				report_mismatch($sformatf("result %0d status %0d, expected %0d", checked, st, e.status));
			if (cnt !== e.count)
				report_mismatch($sformatf("result %0d merges_so_far %0d, expected %0d", checked, cnt,
					e.count));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [3:0]  first_node;
	logic [3:0]  second_node;
	logic [31:0] edge_weight;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] level;
	logic [1:0]  status;
	logic [3:0]  merges_so_far;

	merge_level_tracker sb;
	int items_sent    = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycle_count   = 0;

	single_linkage_merge_levels_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.first_node    (first_node),
		.second_node   (second_node),
		.edge_weight   (edge_weight),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.level         (level),
		.status        (status),
		.merges_so_far (merges_so_far)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("single_linkage_merge_levels_core test failed");
			$finish;
		end
	end

	// monitor both channels, drive out_ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_item(cmd, first_node, second_node, edge_weight);
			if (out_valid && out_ready)
				sb.check_result(level, status, merges_so_far);
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	function automatic logic [31:0] rand_weight();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return 32'h0001_0000;
			default: return $urandom;
		endcase
	endfunction

	// offer one item and wait until it is taken; valid stays high on return
	task automatic send_item(input logic [1:0] c, input logic [3:0] a, input logic [3:0] b,
		input logic [31:0] w);
		int gap;
		// idle pattern follows how far the run has got
		if (items_sent < 470) begin
			send_idle_pct = 20;
			recv_idle_pct = 52;
		end else if (items_sent < 940) begin
			send_idle_pct = 52;
			recv_idle_pct = 20;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		gap = 0;
		while (gap < 24 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			if (in_valid)
				in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= c;
		first_node  <= a;
		second_node <= b;
		edge_weight <= w;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// drop valid and hold until every pending result is back
	task automatic wait_drained();
		if (in_valid)
			in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_node_count(input logic [4:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		sb.set_node_count(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// off-plan item: reads, bad merges, unused code, stray clear
	task automatic send_noise(input int n, input logic [3:0] pa, input logic [3:0] pb);
		case ($urandom_range(0, 11))
			0, 1, 2, 3: send_item(CMD_READ, 4'($urandom_range(0, n - 1)),
				4'($urandom_range(0, n - 1)), $urandom);
			4:          send_item(CMD_READ, 4'($urandom), 4'($urandom), $urandom);
			5, 6:       send_item(CMD_MERGE, 4'($urandom), 4'($urandom), rand_weight());
			7, 8, 9:    send_item(CMD_MERGE, pa, pb, rand_weight());
			10:         send_item(CMD_UNUSED, 4'($urandom), 4'($urandom), $urandom);
			default:    send_item(CMD_CLEAR, 4'($urandom), 4'($urandom), $urandom);
		endcase
	endtask

	// one node_count setting: random spanning trees with noise mixed in
	task automatic run_phase(input logic [4:0] nc, input int quota);
		int         n;
		int         start;
		int         j;
		logic [3:0] t;
		logic [3:0] a;
		logic [3:0] b;
		logic [3:0] perm [NODES];
		wait_drained();
		write_node_count(nc);
		n     = (nc < 1) ? 1 : (nc > NODES) ? NODES : int'(nc);
		start = items_sent;
		while (items_sent - start < quota) begin
			// most trees start from a clean store; the rest build on old labels
			if ($urandom_range(0, 3) != 0)
				send_item(CMD_CLEAR, 4'($urandom), 4'($urandom), $urandom);
			for (int i = 0; i < n; i++)
				perm[i] = 4'(i);
			for (int i = n - 1; i > 0; i--) begin
				j       = $urandom_range(0, i);
				t       = perm[i];
				perm[i] = perm[j];
				perm[j] = t;
			end
			// node perm[i] joins the tree built from perm[0..i-1]
			for (int i = 1; i < n && items_sent - start < quota; i++) begin
				while ($urandom_range(0, 99) < 30)
					send_noise(n, perm[$urandom_range(0, i - 1)], perm[$urandom_range(0, i - 1)]);
				a = perm[i];
				b = perm[$urandom_range(0, i - 1)];
				if ($urandom_range(0, 1) != 0)
					send_item(CMD_MERGE, b, a, rand_weight());
				else
					send_item(CMD_MERGE, a, b, rand_weight());
				if ($urandom_range(0, 39) == 0)
					wait_drained();
			end
			repeat ($urandom_range(1, 3))
				send_item(CMD_READ, 4'($urandom_range(0, n - 1)), 4'($urandom_range(0, n - 1)),
					$urandom);
			// one edge past a full tree
			send_item(CMD_MERGE, 4'($urandom_range(0, n - 1)), 4'($urandom_range(0, n - 1)),
				rand_weight());
		end
	endtask

	initial begin
		logic [4:0] phase_nc [10];
		sb = new();
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= '0;
		in_valid    <= 1'b0;
		cmd         <= CMD_MERGE;
		first_node  <= '0;
		second_node <= '0;
		edge_weight <= '0;
		out_ready   <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset node_count, weight extremes, priorities of the checks
		send_item(CMD_READ,   4'd0,  4'd0,  32'd0);
		send_item(CMD_READ,   4'd15, 4'd15, 32'hFFFF_FFFF);
		send_item(CMD_MERGE,  4'd0,  4'd15, 32'hFFFF_FFFF);
		send_item(CMD_MERGE,  4'd15, 4'd0,  32'h0000_0001);
		send_item(CMD_MERGE,  4'd3,  4'd4,  32'd0);
		send_item(CMD_MERGE,  4'd4,  4'd0,  32'h0001_0000);
		send_item(CMD_READ,   4'd3,  4'd15, 32'd0);
		send_item(CMD_READ,   4'd15, 4'd0,  32'd0);
		send_item(CMD_READ,   4'd4,  4'd4,  32'd0);
		send_item(CMD_UNUSED, 4'd15, 4'd15, 32'hFFFF_FFFF);
		wait_drained();
		send_item(CMD_CLEAR,  4'd15, 4'd15, 32'hFFFF_FFFF);
		send_item(CMD_READ,   4'd0,  4'd15, 32'd0);
		wait_drained();
		write_node_count(5'd4);
		send_item(CMD_MERGE,  4'd0,  4'd4,  32'h1234_5678);
		send_item(CMD_READ,   4'd5,  4'd0,  32'd0);
		send_item(CMD_READ,   4'd0,  4'd3,  32'd0);
		send_item(CMD_MERGE,  4'd0,  4'd1,  32'h1234_5678);
		send_item(CMD_MERGE,  4'd2,  4'd1,  32'h8000_0000);
		send_item(CMD_MERGE,  4'd3,  4'd2,  32'h0000_FFFF);
		// tree full and same component: too-many wins
		send_item(CMD_MERGE,  4'd0,  4'd3,  32'h0000_0002);
		// out of range wins over too-many
		send_item(CMD_MERGE,  4'd15, 4'd0,  32'h0000_0003);
		send_item(CMD_READ,   4'd3,  4'd0,  32'd0);
		// widen again without a clear: labels and levels carry over
		wait_drained();
		write_node_count(5'd16);
		send_item(CMD_MERGE,  4'd4,  4'd0,  32'hDEAD_BEEF);
		send_item(CMD_READ,   4'd2,  4'd4,  32'd0);
		send_item(CMD_CLEAR,  4'd0,  4'd0,  32'd0);
		send_item(CMD_READ,   4'd4,  4'd2,  32'd0);

		// random part over a spread of settings, extremes included
		phase_nc = '{5'd16, 5'd1, 5'd0, 5'd2, 5'd31, 5'd7, 5'd17, 5'd3, 5'd16, 5'd0};
		phase_nc[9] = 5'($urandom_range(0, 31));
		for (int p = 0; p < 10; p++)
			run_phase(phase_nc[p], PHASE_ITEMS);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d items: %0d merge, %0d read, %0d clear, %0d unused code; %0d results checked",
			items_sent, sb.cmd_seen[0], sb.cmd_seen[1], sb.cmd_seen[2], sb.cmd_seen[3], sb.checked);
		$display("status mix ok/range/same/many = %0d/%0d/%0d/%0d over %0d node_count writes",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
			sb.cfg_writes);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("single_linkage_merge_levels_core test passed");
		end else begin
			$display("single_linkage_merge_levels_core test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
